/* sv/strided_2d_convolution_assert.svh */
// ----------------------------------------------------------------------------
// strided_2d_convolution_assert.svh
// assertion macros shared by the convolution rtl, empty under synthesis
// ----------------------------------------------------------------------------
`ifndef STRIDED_2D_CONVOLUTION_ASSERT_SVH
`define STRIDED_2D_CONVOLUTION_ASSERT_SVH

`ifndef SYNTHESIS
// property must hold at every clock outside reset
`define SC2D_ASSERT(lbl, clk, rstn, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) (prop)) else $error(msg);
// condition must never be seen outside reset
`define SC2D_ASSERT_NEVER(lbl, clk, rstn, cond, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) !(cond)) else $error(msg);
`else
`define SC2D_ASSERT(lbl, clk, rstn, prop, msg)
`define SC2D_ASSERT_NEVER(lbl, clk, rstn, cond, msg)
`endif

`endif

/* sv/sc2d_pkg.sv */
// ----------------------------------------------------------------------------
// sc2d_pkg
// shared types, constants and helpers of the strided 2-d convolution
// ----------------------------------------------------------------------------
`default_nettype none

package sc2d_pkg;

    // configuration port
    localparam int CFG_W        = 64;
    localparam int CFG_IDX_W    = 3;
    localparam int IMG_DIM_W    = 11;
    localparam int KDIM_W       = 2;
    localparam int STRIDE_W     = 3;
    localparam int COEFF_SLOT_W = 16;
    localparam int COEF_IDX_W   = 4;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_IMAGE_WIDTH  = 3'd0,
        CFG_IMAGE_HEIGHT = 3'd1,
        CFG_KERNEL_ROWS  = 3'd2,
        CFG_KERNEL_COLS  = 3'd3,
        CFG_STRIDE       = 3'd4,
        CFG_COEFF_A      = 3'd5,
        CFG_COEFF_B      = 3'd6,
        CFG_COEFF_C      = 3'd7
    } cfg_index_t;

    // stream fields
    localparam int IN_PIXEL_W = 8;
    localparam int SUM_W      = 28;
    localparam int OROW_W     = 10;
    localparam int OCOL_W     = 10;
    localparam int ROW_CNT_W  = 10;

    // position arithmetic width, covers columns up to 4095 plus one
    localparam int IDX_W      = 13;
    localparam int MAX_HEIGHT = 1024;
    localparam int MAX_STRIDE = 4;

    // x / 3 == (x * 2731) >> 13 for every x below 8192
    localparam int DIV3_MUL   = 2731;
    localparam int DIV3_SHIFT = 13;

    // result queue
    localparam int OFIFO_DEPTH = 8;
    localparam int OFIFO_AW    = 3;

    typedef struct packed {
        logic signed [SUM_W-1:0]  sum;
        logic [OROW_W-1:0]        out_row;
        logic [OCOL_W-1:0]        out_col;
        logic                     frame_end;
    } result_t;

    // divide a position by a stride of 1 to 4
    function automatic logic [IDX_W-1:0] div_stride(input logic [IDX_W-1:0] x,
                                                    input logic [STRIDE_W-1:0] s);
        logic [2*IDX_W-1:0] prod;
        logic [IDX_W-1:0]   q;
        prod = (2*IDX_W)'(x) * (2*IDX_W)'(DIV3_MUL);
        case (s)
            3'd2:    q = x >> 1;
            3'd3:    q = prod[DIV3_SHIFT +: IDX_W];
            3'd4:    q = x >> 2;
            default: q = x;
        endcase
        return q;
    endfunction

endpackage

`default_nettype wire

/* sv/strided_2d_convolution.sv */
// ----------------------------------------------------------------------------
// strided_2d_convolution
// valid 2-d convolution of a raster pixel stream with a configurable stride
// ----------------------------------------------------------------------------
// a pixel accepted that completes a window shows its result on m_valid once it has
//   passed the line store read, window, multiply, row sums and queue registers
// throughput: one pixel per clock; s_ready drops only while 8 results are owed
//   to the result channel (depth of the result queue)
// reset: synchronous, active low; clears counters, phases, window and config
//   (1024 x 1024, 3 x 3 kernel, stride 1, zero coefficients); line store is kept
`default_nettype none

`include "strided_2d_convolution_assert.svh"

module strided_2d_convolution #(
    parameter int MAX_WIDTH  = 1024,
    parameter int MAX_KERNEL = 3,
    parameter int PIXEL_BITS = 8,
    parameter int COEFF_BITS = 16
) (
    input  wire logic                                   aclk,
    input  wire logic                                   aresetn,
    // configuration writes
    input  wire logic                                   cfg_we,
    input  wire logic [sc2d_pkg::CFG_IDX_W-1:0]         cfg_index,
    input  wire logic [sc2d_pkg::CFG_W-1:0]             cfg_data,
    // pixel stream
    input  wire logic                                   s_valid,
    output logic                                        s_ready,
    input  wire logic [sc2d_pkg::IN_PIXEL_W-1:0]        s_pixel,
    // result stream
    output logic                                        m_valid,
    input  wire logic                                   m_ready,
    output logic signed [sc2d_pkg::SUM_W-1:0]           m_sum,
    output logic [sc2d_pkg::OROW_W-1:0]                 m_out_row,
    output logic [sc2d_pkg::OCOL_W-1:0]                 m_out_col,
    output logic                                        m_frame_end
);

    import sc2d_pkg::*;

    localparam int K       = MAX_KERNEL;
    localparam int COL_W   = $clog2(MAX_WIDTH);
    localparam int WCNT_W  = $clog2(MAX_WIDTH + 1);
    localparam int PROD_W  = PIXEL_BITS + COEFF_BITS + 1;
    localparam int ROW_W   = PROD_W + 2;
    localparam int ACC_W   = ROW_W + 2;
    localparam int USED_W  = $clog2(OFIFO_DEPTH + 1);

    // ------------------------------------------------------------------
    // configuration registers
    // ------------------------------------------------------------------
    logic [IMG_DIM_W-1:0]     image_width_reg;
    logic [IMG_DIM_W-1:0]     image_height_reg;
    logic [KDIM_W-1:0]        kernel_rows_reg;
    logic [KDIM_W-1:0]        kernel_cols_reg;
    logic [STRIDE_W-1:0]      stride_reg;
    logic [CFG_W-1:0]         coeff_a_reg;
    logic [CFG_W-1:0]         coeff_b_reg;
    logic [COEFF_SLOT_W-1:0]  coeff_c_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            image_width_reg  <= IMG_DIM_W'(1024);
            image_height_reg <= IMG_DIM_W'(1024);
            kernel_rows_reg  <= KDIM_W'(3);
            kernel_cols_reg  <= KDIM_W'(3);
            stride_reg       <= STRIDE_W'(1);
            coeff_a_reg      <= '0;
            coeff_b_reg      <= '0;
            coeff_c_reg      <= '0;
        end else if (cfg_we) begin
            case (cfg_index_t'(cfg_index))
                CFG_IMAGE_WIDTH:  image_width_reg  <= cfg_data[IMG_DIM_W-1:0];
                CFG_IMAGE_HEIGHT: image_height_reg <= cfg_data[IMG_DIM_W-1:0];
                CFG_KERNEL_ROWS:  kernel_rows_reg  <= cfg_data[KDIM_W-1:0];
                CFG_KERNEL_COLS:  kernel_cols_reg  <= cfg_data[KDIM_W-1:0];
                CFG_STRIDE:       stride_reg       <= cfg_data[STRIDE_W-1:0];
                CFG_COEFF_A:      coeff_a_reg      <= cfg_data;
                CFG_COEFF_B:      coeff_b_reg      <= cfg_data;
                CFG_COEFF_C:      coeff_c_reg      <= cfg_data[COEFF_SLOT_W-1:0];
                default: ;
            endcase
        end
    end

    // effective settings: zero acts as one, large values saturate
    logic [WCNT_W-1:0]    w_eff;
    logic [IMG_DIM_W-1:0] h_eff;
    logic [KDIM_W-1:0]    kr_eff;
    logic [KDIM_W-1:0]    kc_eff;
    logic [STRIDE_W-1:0]  s_eff;

    always_comb begin
        if (image_width_reg == '0) begin
            w_eff = WCNT_W'(1);
        end else if (IDX_W'(image_width_reg) > IDX_W'(MAX_WIDTH)) begin
            w_eff = WCNT_W'(MAX_WIDTH);
        end else begin
            w_eff = WCNT_W'(image_width_reg);
        end

        if (image_height_reg == '0) begin
            h_eff = IMG_DIM_W'(1);
        end else if (image_height_reg > IMG_DIM_W'(MAX_HEIGHT)) begin
            h_eff = IMG_DIM_W'(MAX_HEIGHT);
        end else begin
            h_eff = image_height_reg;
        end

        if (kernel_rows_reg == '0) begin
            kr_eff = KDIM_W'(1);
        end else if (kernel_rows_reg > KDIM_W'(K)) begin
            kr_eff = KDIM_W'(K);
        end else begin
            kr_eff = kernel_rows_reg;
        end

        if (kernel_cols_reg == '0) begin
            kc_eff = KDIM_W'(1);
        end else if (kernel_cols_reg > KDIM_W'(K)) begin
            kc_eff = KDIM_W'(K);
        end else begin
            kc_eff = kernel_cols_reg;
        end

        if (stride_reg == '0) begin
            s_eff = STRIDE_W'(1);
        end else if (stride_reg > STRIDE_W'(MAX_STRIDE)) begin
            s_eff = STRIDE_W'(MAX_STRIDE);
        end else begin
            s_eff = stride_reg;
        end
    end

    logic [IDX_W-1:0] w_x;
    logic [IDX_W-1:0] h_x;
    logic [IDX_W-1:0] kr_x;
    logic [IDX_W-1:0] kc_x;

    assign w_x  = IDX_W'(w_eff);
    assign h_x  = IDX_W'(h_eff);
    assign kr_x = IDX_W'(kr_eff);
    assign kc_x = IDX_W'(kc_eff);

    // last output position of the frame, registered from the config in the next cycle
    logic             lim_ok_reg;
    logic [IDX_W-1:0] lim_row_reg;
    logic [IDX_W-1:0] lim_col_reg;

    always_ff @(posedge aclk) begin
        lim_ok_reg  <= (h_x >= kr_x) && (w_x >= kc_x);
        lim_row_reg <= div_stride(h_x - kr_x, s_eff);
        lim_col_reg <= div_stride(w_x - kc_x, s_eff);
    end

    // ------------------------------------------------------------------
    // input side: position counters and the stride grid
    // ------------------------------------------------------------------
    logic [COL_W-1:0]     in_col_reg;
    logic [ROW_CNT_W-1:0] in_row_reg;
    logic [1:0]           col_phase_reg;
    logic [1:0]           row_phase_reg;
    logic [COL_W-1:0]     in_col_next;
    logic [ROW_CNT_W-1:0] in_row_next;
    logic [1:0]           col_phase_next;
    logic [1:0]           row_phase_next;

    logic                 accept;
    logic [IDX_W-1:0]     c1;
    logic [IDX_W-1:0]     r1;
    logic                 col_ok;
    logic                 row_ok;
    logic                 emit_now;
    logic [IDX_W-1:0]     orow_now;
    logic [IDX_W-1:0]     ocol_now;
    logic [2:0]           col_ph1;
    logic [2:0]           row_ph1;
    logic [PIXEL_BITS-1:0] pix_now;

    logic [USED_W-1:0]    used_reg;

    assign s_ready = (used_reg < USED_W'(OFIFO_DEPTH));
    assign accept  = s_valid && s_ready;
    assign pix_now = PIXEL_BITS'(s_pixel);

    assign c1       = IDX_W'(in_col_reg) + IDX_W'(1);
    assign r1       = IDX_W'(in_row_reg) + IDX_W'(1);
    assign col_ok   = (c1 >= kc_x);
    assign row_ok   = (r1 >= kr_x);
    assign emit_now = row_ok && col_ok && (row_phase_reg == '0) && (col_phase_reg == '0);
    assign orow_now = div_stride(r1 - kr_x, s_eff);
    assign ocol_now = div_stride(c1 - kc_x, s_eff);
    assign col_ph1  = {1'b0, col_phase_reg} + 3'd1;
    assign row_ph1  = {1'b0, row_phase_reg} + 3'd1;

    always_comb begin
        in_col_next    = in_col_reg;
        in_row_next    = in_row_reg;
        col_phase_next = col_phase_reg;
        row_phase_next = row_phase_reg;

        // column phase runs once the window fits horizontally
        if (col_ok) begin
            col_phase_next = (col_ph1 >= s_eff) ? 2'd0 : col_ph1[1:0];
        end

        if (c1 >= w_x) begin
            // end of row
            in_col_next    = '0;
            col_phase_next = '0;
            if (row_ok) begin
                row_phase_next = (row_ph1 >= s_eff) ? 2'd0 : row_ph1[1:0];
            end
            if (r1 >= h_x) begin
                in_row_next    = '0;
                row_phase_next = '0;
            end else begin
                in_row_next = ROW_CNT_W'(r1);
            end
        end else begin
            in_col_next = COL_W'(c1);
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_col_reg    <= '0;
            in_row_reg    <= '0;
            col_phase_reg <= '0;
            row_phase_reg <= '0;
        end else if (accept) begin
            in_col_reg    <= in_col_next;
            in_row_reg    <= in_row_next;
            col_phase_reg <= col_phase_next;
            row_phase_reg <= row_phase_next;
        end
    end

    // ------------------------------------------------------------------
    // stage 1: line store word arrives, window shifts at the end
    // ------------------------------------------------------------------
    logic                  s1_valid_reg;
    logic                  s1_emit_reg;
    logic [COL_W-1:0]      s1_col_reg;
    logic [PIXEL_BITS-1:0] s1_pix_reg;
    logic [IDX_W-1:0]      s1_orow_reg;
    logic [IDX_W-1:0]      s1_ocol_reg;

    // stages 2 to 4 carry the result tags
    logic                  s2_emit_reg;
    logic                  s2_last_reg;
    logic [OROW_W-1:0]     s2_orow_reg;
    logic [OCOL_W-1:0]     s2_ocol_reg;
    logic                  s3_emit_reg;
    logic                  s3_last_reg;
    logic [OROW_W-1:0]     s3_orow_reg;
    logic [OCOL_W-1:0]     s3_ocol_reg;
    logic                  s4_emit_reg;
    logic                  s4_last_reg;
    logic [OROW_W-1:0]     s4_orow_reg;
    logic [OCOL_W-1:0]     s4_ocol_reg;

    logic                  s1_last;

    assign s1_last = lim_ok_reg && (s1_orow_reg == lim_row_reg) &&
                     (s1_ocol_reg == lim_col_reg);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            s1_valid_reg <= 1'b0;
            s1_emit_reg  <= 1'b0;
            s2_emit_reg  <= 1'b0;
            s3_emit_reg  <= 1'b0;
            s4_emit_reg  <= 1'b0;
        end else begin
            s1_valid_reg <= accept;
            s1_emit_reg  <= accept && emit_now;
            s2_emit_reg  <= s1_emit_reg;
            s3_emit_reg  <= s2_emit_reg;
            s4_emit_reg  <= s3_emit_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (accept) begin
            s1_col_reg  <= in_col_reg;
            s1_pix_reg  <= pix_now;
            s1_orow_reg <= orow_now;
            s1_ocol_reg <= ocol_now;
        end
        s2_last_reg <= s1_last;
        s2_orow_reg <= OROW_W'(s1_orow_reg);
        s2_ocol_reg <= OCOL_W'(s1_ocol_reg);
        s3_last_reg <= s2_last_reg;
        s3_orow_reg <= s2_orow_reg;
        s3_ocol_reg <= s2_ocol_reg;
        s4_last_reg <= s3_last_reg;
        s4_orow_reg <= s3_orow_reg;
        s4_ocol_reg <= s3_ocol_reg;
    end

    // new window column: rows above from the line store, bottom is the pixel
    logic [PIXEL_BITS-1:0] col_pix [K];

    assign col_pix[K-1] = s1_pix_reg;

    generate
        if (K > 1) begin : g_lines
            logic [K-2:0][PIXEL_BITS-1:0] line_word;

            sc2d_linebuf #(
                .DEPTH      (MAX_WIDTH),
                .PIXEL_BITS (PIXEL_BITS),
                .ROWS       (K - 1)
            ) u_linebuf (
                .aclk    (aclk),
                .aresetn (aresetn),
                .rd_en   (accept),
                .rd_addr (in_col_reg),
                .wr_en   (s1_valid_reg),
                .wr_addr (s1_col_reg),
                .wr_pix  (s1_pix_reg),
                .rd_word (line_word)
            );

            for (genvar t = 0; t < K - 1; t++) begin : g_col
                assign col_pix[K-2-t] = line_word[t];
            end
        end
    endgenerate

    // ------------------------------------------------------------------
    // coefficient per window tap, aligned to the bottom right corner
    // ------------------------------------------------------------------
    function automatic logic signed [COEFF_BITS-1:0] coeff_pick(
        input logic [COEF_IDX_W-1:0] k
    );
        logic [COEFF_SLOT_W-1:0] slot;
        case (k)
            4'd0:    slot = coeff_a_reg[15:0];
            4'd1:    slot = coeff_a_reg[31:16];
            4'd2:    slot = coeff_a_reg[47:32];
            4'd3:    slot = coeff_a_reg[63:48];
            4'd4:    slot = coeff_b_reg[15:0];
            4'd5:    slot = coeff_b_reg[31:16];
            4'd6:    slot = coeff_b_reg[47:32];
            4'd7:    slot = coeff_b_reg[63:48];
            4'd8:    slot = coeff_c_reg;
            default: slot = '0;
        endcase
        return $signed(slot[COEFF_BITS-1:0]);
    endfunction

    logic signed [COEFF_BITS-1:0] cell_coeff [K][K];

    always_comb begin
        logic [COEF_IDX_W-1:0] off_r;
        logic [COEF_IDX_W-1:0] off_c;
        logic [COEF_IDX_W-1:0] ri;
        logic [COEF_IDX_W-1:0] cj;
        logic [COEF_IDX_W-1:0] idx;
        off_r = COEF_IDX_W'(K) - COEF_IDX_W'(kr_eff);
        off_c = COEF_IDX_W'(K) - COEF_IDX_W'(kc_eff);
        for (int i = 0; i < K; i++) begin
            for (int j = 0; j < K; j++) begin
                ri  = COEF_IDX_W'(i) - off_r;
                cj  = COEF_IDX_W'(j) - off_c;
                idx = ri * COEF_IDX_W'(kc_eff) + cj;
                if ((COEF_IDX_W'(i) >= off_r) && (COEF_IDX_W'(j) >= off_c)) begin
                    cell_coeff[i][j] = coeff_pick(idx);
                end else begin
                    cell_coeff[i][j] = '0;
                end
            end
        end
    end

    // ------------------------------------------------------------------
    // window: K rows of K cells, each row shifts left on every pixel
    // ------------------------------------------------------------------
    logic [PIXEL_BITS-1:0]    win_pix  [K][K];
    logic signed [PROD_W-1:0] win_prod [K][K];

    generate
        for (genvar i = 0; i < K; i++) begin : g_row
            for (genvar j = 0; j < K; j++) begin : g_tap
                logic [PIXEL_BITS-1:0] tap_in;
                if (j == K - 1) begin : g_edge
                    assign tap_in = col_pix[i];
                end else begin : g_inner
                    assign tap_in = win_pix[i][j+1];
                end

                sc2d_cell #(
                    .PIXEL_BITS (PIXEL_BITS),
                    .COEFF_BITS (COEFF_BITS)
                ) u_cell (
                    .aclk     (aclk),
                    .aresetn  (aresetn),
                    .shift_en (s1_valid_reg),
                    .pix_in   (tap_in),
                    .coeff_in (cell_coeff[i][j]),
                    .pix_out  (win_pix[i][j]),
                    .prod_out (win_prod[i][j])
                );
            end
        end
    endgenerate

    // ------------------------------------------------------------------
    // stage 3: row sums, stage 4: total into the result queue
    // ------------------------------------------------------------------
    logic signed [ROW_W-1:0] row_sum_next [K];
    logic signed [ROW_W-1:0] row_sum_reg  [K];
    logic signed [ACC_W-1:0] total_sum;

    always_comb begin
        for (int i = 0; i < K; i++) begin
            row_sum_next[i] = '0;
            for (int j = 0; j < K; j++) begin
                row_sum_next[i] = row_sum_next[i] + ROW_W'(win_prod[i][j]);
            end
        end
    end

    always_ff @(posedge aclk) begin
        for (int i = 0; i < K; i++) begin
            row_sum_reg[i] <= row_sum_next[i];
        end
    end

    always_comb begin
        total_sum = '0;
        for (int i = 0; i < K; i++) begin
            total_sum = total_sum + ACC_W'(row_sum_reg[i]);
        end
    end

    result_t fifo_wr_data;
    result_t fifo_rd_data;

    always_comb begin
        fifo_wr_data.sum       = SUM_W'(total_sum);
        fifo_wr_data.out_row   = s4_orow_reg;
        fifo_wr_data.out_col   = s4_ocol_reg;
        fifo_wr_data.frame_end = s4_last_reg;
    end

    sc2d_ofifo u_ofifo (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .wr_en    (s4_emit_reg),
        .wr_data  (fifo_wr_data),
        .rd_en    (m_ready),
        .rd_valid (m_valid),
        .rd_data  (fifo_rd_data)
    );

    assign m_sum       = fifo_rd_data.sum;
    assign m_out_row   = fifo_rd_data.out_row;
    assign m_out_col   = fifo_rd_data.out_col;
    assign m_frame_end = fifo_rd_data.frame_end;

    // ------------------------------------------------------------------
    // queue credits: one per accepted beat that will produce a result
    // ------------------------------------------------------------------
    logic used_inc;
    logic used_dec;

    assign used_inc = accept && emit_now;
    assign used_dec = m_valid && m_ready;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            used_reg <= '0;
        end else if (used_inc && !used_dec) begin
            used_reg <= used_reg + 1'b1;
        end else if (used_dec && !used_inc) begin
            used_reg <= used_reg - 1'b1;
        end
    end

    // ------------------------------------------------------------------
    // assertions
    // ------------------------------------------------------------------
    `SC2D_ASSERT(a_credit_max, aclk, aresetn, used_reg <= USED_W'(OFIFO_DEPTH), "credit count above queue depth")
    `SC2D_ASSERT(a_out_credited, aclk, aresetn, m_valid |-> (used_reg != '0), "result beat without credit")
    `SC2D_ASSERT(a_inflight_credited, aclk, aresetn, $countones({s1_emit_reg, s2_emit_reg, s3_emit_reg, s4_emit_reg}) <= used_reg, "in-flight results exceed credits")

endmodule

`default_nettype wire

/* sv/sc2d_cell.sv */
// ----------------------------------------------------------------------------
// sc2d_cell
// one window tap: holds a pixel, passes it to its left neighbor, multiplies
// ----------------------------------------------------------------------------
`default_nettype none

module sc2d_cell #(
    parameter int PIXEL_BITS = 8,
    parameter int COEFF_BITS = 16
) (
    input  wire logic                                  aclk,
    input  wire logic                                  aresetn,
    input  wire logic                                  shift_en,
    input  wire logic [PIXEL_BITS-1:0]                 pix_in,
    input  wire logic signed [COEFF_BITS-1:0]          coeff_in,
    output logic [PIXEL_BITS-1:0]                      pix_out,
    output logic signed [PIXEL_BITS+COEFF_BITS:0]      prod_out
);

    localparam int PROD_W = PIXEL_BITS + COEFF_BITS + 1;

    logic [PIXEL_BITS-1:0]          pix_reg;
    logic signed [COEFF_BITS-1:0]   coeff_reg;
    logic signed [PROD_W-1:0]       prod_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            pix_reg <= '0;
        end else if (shift_en) begin
            pix_reg <= pix_in;
        end
    end

    // unsigned pixel times signed coefficient
    // taps outside the kernel carry a zero coefficient and add nothing,
    // whatever stale line store data they hold
    always_ff @(posedge aclk) begin
        coeff_reg <= coeff_in;
        if (coeff_reg == '0) begin
            prod_reg <= '0;
        end else begin
            prod_reg <= $signed({1'b0, pix_reg}) * coeff_reg;
        end
    end

    assign pix_out  = pix_reg;
    assign prod_out = prod_reg;

endmodule

`default_nettype wire

/* sv/sc2d_linebuf.sv */
// ----------------------------------------------------------------------------
// sc2d_linebuf
// line store: one word per column holding the previous rows of that column
// ----------------------------------------------------------------------------
`default_nettype none

module sc2d_linebuf #(
    parameter int DEPTH      = 1024,
    parameter int PIXEL_BITS = 8,
    parameter int ROWS       = 2
) (
    input  wire logic                               aclk,
    input  wire logic                               aresetn,
    input  wire logic                               rd_en,
    input  wire logic [$clog2(DEPTH)-1:0]           rd_addr,
    input  wire logic                               wr_en,
    input  wire logic [$clog2(DEPTH)-1:0]           wr_addr,
    input  wire logic [PIXEL_BITS-1:0]              wr_pix,
    output logic [ROWS-1:0][PIXEL_BITS-1:0]         rd_word
);

    logic [ROWS-1:0][PIXEL_BITS-1:0] mem [DEPTH];
    logic [ROWS-1:0][PIXEL_BITS-1:0] rd_data_reg;
    logic [ROWS-1:0][PIXEL_BITS-1:0] fwd_word_reg;
    logic                            fwd_reg;
    logic [ROWS-1:0][PIXEL_BITS-1:0] word_new;

    // read word, or the word being written back when the read hit it
    assign rd_word = fwd_reg ? fwd_word_reg : rd_data_reg;

    // age the column: newest pixel in slot 0
    always_comb begin
        word_new[0] = wr_pix;
        for (int t = 1; t < ROWS; t++) begin
            word_new[t] = rd_word[t-1];
        end
    end

    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem[wr_addr] <= word_new;
        end
        if (rd_en) begin
            rd_data_reg <= mem[rd_addr];
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            fwd_reg <= 1'b0;
        end else if (rd_en) begin
            fwd_reg <= wr_en && (rd_addr == wr_addr);
        end
    end

    always_ff @(posedge aclk) begin
        if (rd_en) begin
            fwd_word_reg <= word_new;
        end
    end

endmodule

`default_nettype wire

/* sv/sc2d_ofifo.sv */
// ----------------------------------------------------------------------------
// sc2d_ofifo
// small result queue between the pipeline and the result channel
// ----------------------------------------------------------------------------
`default_nettype none

module sc2d_ofifo (
    input  wire logic              aclk,
    input  wire logic              aresetn,
    input  wire logic              wr_en,
    input  wire sc2d_pkg::result_t wr_data,
    input  wire logic              rd_en,
    output logic                   rd_valid,
    output sc2d_pkg::result_t      rd_data
);

    import sc2d_pkg::*;

    result_t              buf_mem [OFIFO_DEPTH];
    logic [OFIFO_AW:0]    wr_ptr_reg;
    logic [OFIFO_AW:0]    rd_ptr_reg;

    assign rd_valid = (wr_ptr_reg != rd_ptr_reg);
    assign rd_data  = buf_mem[rd_ptr_reg[OFIFO_AW-1:0]];

    always_ff @(posedge aclk) begin
        if (wr_en) begin
            buf_mem[wr_ptr_reg[OFIFO_AW-1:0]] <= wr_data;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
        end else begin
            if (wr_en) begin
                wr_ptr_reg <= wr_ptr_reg + 1'b1;
            end
            if (rd_en && rd_valid) begin
                rd_ptr_reg <= rd_ptr_reg + 1'b1;
            end
        end
    end

endmodule

`default_nettype wire

/* tb/tb.sv */
// ----------------------------------------------------------------------------
// tb
// Self-checking bench for the strided 2-d convolution. It streams whole raster
// frames under many kernel, stride and image-size settings, with random sender
// bursts and receiver stalls. A scoreboard keeps its own line stores and window
// taps, predicts every window sum, and compares each result beat field by field.
// ----------------------------------------------------------------------------
module tb;
    import sc2d_pkg::*;

    localparam int LIMIT_CYCLES  = 600000;
    localparam int SETTLE_CYCLES = 12;      // covers the result pipeline, with a margin
    localparam int RANDOM_PIXELS = 1000;
    localparam int MAX_PRINTS    = 40;
    localparam int MAX_COLS      = 1024;
    localparam int KMAX          = 3;
    localparam int LONG_HOLD     = 400;

    typedef enum logic [1:0] {
        SINK_OPEN,
        SINK_COIN,
        SINK_SPARSE,
        SINK_TOGGLE
    } sink_mode_t;

    // predicts window sums from the accepted pixel stream and holds them in order
    class window_sum_board;
        logic [IN_PIXEL_W-1:0] prev_rows [0:KMAX-2][0:MAX_COLS-1];
        logic [IN_PIXEL_W-1:0] taps [0:KMAX-1][0:KMAX-1];
        int unsigned           col_pos, row_pos, col_ph, row_ph;
        logic [IMG_DIM_W-1:0]  width_reg, height_reg;
        logic [KDIM_W-1:0]     krows_reg, kcols_reg;
        logic [STRIDE_W-1:0]   stride_reg;
        logic [CFG_W-1:0]      coeff_a, coeff_b;
        logic [COEFF_SLOT_W-1:0] coeff_c;
        result_t               expected_sums [$];
        int                    errors;

        function new();
            for (int i = 0; i < KMAX - 1; i++)
                for (int c = 0; c < MAX_COLS; c++)
                    prev_rows[i][c] = '0;
            for (int i = 0; i < KMAX; i++)
                for (int j = 0; j < KMAX; j++)
                    taps[i][j] = '0;
            col_pos = 0;
            row_pos = 0;
            col_ph = 0;
            row_ph = 0;
            width_reg = 11'd1024;
            height_reg = 11'd1024;
            krows_reg = 2'd3;
            kcols_reg = 2'd3;
            stride_reg = 3'd1;
            coeff_a = '0;
            coeff_b = '0;
            coeff_c = '0;
            errors = 0;
        endfunction

        static function int unsigned saturate(int unsigned v, int unsigned hi);
            if (v == 0) return 1;
            return (v > hi) ? hi : v;
        endfunction

        function void set_reg(cfg_index_t idx, logic [CFG_W-1:0] value);
            case (idx)
                CFG_IMAGE_WIDTH:  width_reg  = value[IMG_DIM_W-1:0];
                CFG_IMAGE_HEIGHT: height_reg = value[IMG_DIM_W-1:0];
                CFG_KERNEL_ROWS:  krows_reg  = value[KDIM_W-1:0];
                CFG_KERNEL_COLS:  kcols_reg  = value[KDIM_W-1:0];
                CFG_STRIDE:       stride_reg = value[STRIDE_W-1:0];
                CFG_COEFF_A:      coeff_a    = value;
                CFG_COEFF_B:      coeff_b    = value;
                CFG_COEFF_C:      coeff_c    = value[COEFF_SLOT_W-1:0];
                default:          ;
            endcase
        endfunction

        function longint coeff(int unsigned k);
            logic [CFG_W-1:0]               word;
            logic signed [COEFF_SLOT_W-1:0] slot;
            word = (k < 4) ? coeff_a : ((k < 8) ? coeff_b : {48'd0, coeff_c});
            slot = word[(k % 4) * COEFF_SLOT_W +: COEFF_SLOT_W];
            return longint'(slot);
        endfunction

        function void note_pixel(logic [IN_PIXEL_W-1:0] pix);
            int unsigned w, h, kr, kc, s, c, r, orow, ocol;
            longint      acc, tap;
            result_t     res;
            w  = saturate(width_reg, MAX_COLS);
            h  = saturate(height_reg, MAX_HEIGHT);
            kr = saturate(krows_reg, KMAX);
            kc = saturate(kcols_reg, KMAX);
            s  = saturate(stride_reg, MAX_STRIDE);
            c  = col_pos % MAX_COLS;
            r  = row_pos;
            // shift taps left, new column from the pixel and the line stores
            for (int i = 0; i < KMAX; i++)
                for (int j = 0; j < KMAX - 1; j++)
                    taps[i][j] = taps[i][j+1];
            taps[2][2] = pix;
            taps[1][2] = prev_rows[0][c];
            taps[0][2] = prev_rows[1][c];
            prev_rows[1][c] = prev_rows[0][c];
            prev_rows[0][c] = pix;

            if (r + 1 >= kr && c + 1 >= kc && row_ph == 0 && col_ph == 0) begin
                acc = 0;
                for (int i = 0; i < kr; i++)
                    for (int j = 0; j < kc; j++) begin
                        tap = taps[KMAX - kr + i][KMAX - kc + j];
                        acc += coeff(i * kc + j) * tap;
                    end
                orow = (r + 1 - kr) / s;
                ocol = (c + 1 - kc) / s;
                res.sum       = acc[SUM_W-1:0];
                res.out_row   = orow[OROW_W-1:0];
                res.out_col   = ocol[OCOL_W-1:0];
                res.frame_end = (h >= kr && w >= kc &&
                                 orow == (h - kr) / s && ocol == (w - kc) / s);
                expected_sums.push_back(res);
            end

            if (c + 1 >= kc)
                col_ph = (col_ph + 1 >= s) ? 0 : col_ph + 1;
            if (c + 1 >= w) begin
                col_pos = 0;
                col_ph = 0;
                if (r + 1 >= kr)
                    row_ph = (row_ph + 1 >= s) ? 0 : row_ph + 1;
                if (r + 1 >= h) begin
                    row_pos = 0;
                    row_ph = 0;
                end else begin
                    row_pos = r + 1;
                end
            end else begin
                col_pos = c + 1;
            end
        endfunction

        function void flag(string field, longint want, longint got);
            if (errors < MAX_PRINTS)
                $display("%0t %s mismatch: expected %0d, actual %0d", $time, field, want, got);
            errors++;
        endfunction

        function void check_result(result_t got);
            result_t want;
            if (expected_sums.size() == 0) begin
                if (errors < MAX_PRINTS)
                    $display("%0t unexpected result: expected none, actual sum %0d row %0d col %0d",
                             $time, got.sum, got.out_row, got.out_col);
                errors++;
                return;
            end
            want = expected_sums.pop_front();
            if (got.sum !== want.sum)             flag("sum", want.sum, got.sum);
            if (got.out_row !== want.out_row)     flag("out_row", want.out_row, got.out_row);
            if (got.out_col !== want.out_col)     flag("out_col", want.out_col, got.out_col);
            if (got.frame_end !== want.frame_end) flag("frame_end", want.frame_end, got.frame_end);
        endfunction
    endclass

    // clock, reset and block ports; the ones the bench drives are known from time zero
    logic                    aclk        = 1'b0;
    logic                    aresetn     = 1'b0;
    logic                    cfg_we      = 1'b0;
    logic [CFG_IDX_W-1:0]    cfg_index   = CFG_IMAGE_WIDTH;
    logic [CFG_W-1:0]        cfg_data    = '0;
    logic                    s_valid     = 1'b0;
    logic                    s_ready;
    logic [IN_PIXEL_W-1:0]   s_pixel     = '0;
    logic                    m_valid;
    logic                    m_ready     = 1'b0;
    logic signed [SUM_W-1:0] m_sum;
    logic [OROW_W-1:0]       m_out_row;
    logic [OCOL_W-1:0]       m_out_col;
    logic                    m_frame_end;

    window_sum_board board;
    int  pixels_sent = 0;
    int  burst_left  = 0;
    int  cycle_count = 0;
    bit  no_gaps     = 1'b0;     // sender streams without gaps
    bit  backlog_req = 1'b0;     // asks the sink for one long hold-off

    strided_2d_convolution DUT (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .cfg_we      (cfg_we),
        .cfg_index   (cfg_index),
        .cfg_data    (cfg_data),
        .s_valid     (s_valid),
        .s_ready     (s_ready),
        .s_pixel     (s_pixel),
        .m_valid     (m_valid),
        .m_ready     (m_ready),
        .m_sum       (m_sum),
        .m_out_row   (m_out_row),
        .m_out_col   (m_out_col),
        .m_frame_end (m_frame_end)
    );

    always begin
        #5 aclk = 1'b1;
        #5 aclk = 1'b0;
    end

    // result monitor and watchdog; values read here are the ones at the edge
    always @(posedge aclk) begin
        cycle_count++;
        if (aresetn && m_valid && m_ready)
            board.check_result({m_sum, m_out_row, m_out_col, m_frame_end});
        if (cycle_count >= LIMIT_CYCLES) begin
            $display("TB_ERROR");
            $finish;
        end
    end

    // result sink: switches between stall patterns, plus one long hold-off on request
    initial begin : result_sink
        int         hold_cycles;
        int         mode_left;
        bit         backlog_seen;
        sink_mode_t mode;
        hold_cycles = 0;
        mode_left = 0;
        backlog_seen = 1'b0;
        mode = SINK_OPEN;
        forever begin
            @(posedge aclk);
            if (backlog_req && !backlog_seen) begin
                hold_cycles = LONG_HOLD;
                backlog_seen = 1'b1;
            end
            if (!backlog_req)
                backlog_seen = 1'b0;
            if (mode_left == 0) begin
                mode = sink_mode_t'($urandom_range(0, 3));
                mode_left = $urandom_range(8, 60);
            end
            mode_left--;
            if (hold_cycles != 0) begin
                hold_cycles--;
                m_ready <= 1'b0;
            end else begin
                case (mode)
                    SINK_OPEN:   m_ready <= 1'b1;
                    SINK_COIN:   m_ready <= 1'($urandom_range(0, 1));
                    SINK_SPARSE: m_ready <= ($urandom_range(0, 3) == 0);
                    default:     m_ready <= ~m_ready;
                endcase
            end
        end
    end

    // mostly random pixels, with the extremes now and then
    function automatic logic [IN_PIXEL_W-1:0] random_pixel();
        case ($urandom_range(0, 7))
            0:       return '0;
            1:       return '1;
            default: return IN_PIXEL_W'($urandom);
        endcase
    endfunction

    // random bits above a register's width, which the block must drop
    function automatic logic [CFG_W-1:0] with_junk(logic [CFG_W-1:0] v, int bits);
        logic [CFG_W-1:0] junk;
        junk = {$urandom, $urandom};
        if ($urandom_range(0, 1) == 0) return v;
        return (junk << bits) | v;
    endfunction

    // one register write; caller drops cfg_we after the last one of a group
    task automatic write_reg(input cfg_index_t idx, input logic [CFG_W-1:0] value);
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= value;
        @(posedge aclk);
        board.set_reg(idx, value);
    endtask

    // one input beat, with a random gap opening each new burst
    task automatic send_pixel(input logic [IN_PIXEL_W-1:0] pix);
        int gap;
        if (burst_left == 0 && !no_gaps) begin
            gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
            if (gap > 0) begin
                s_valid <= 1'b0;
                repeat (gap) @(posedge aclk);
            end
            burst_left = $urandom_range(1, 40);
        end
        if (burst_left > 0)
            burst_left--;
        s_valid <= 1'b1;
        s_pixel <= pix;
        do @(posedge aclk); while (!s_ready);
        board.note_pixel(pix);
        pixels_sent++;
    endtask

    // sender pauses until every owed result is out and the pipe is empty
    task automatic drain_results();
        s_valid <= 1'b0;
        burst_left = 0;
        while (board.expected_sums.size() != 0) @(posedge aclk);
        repeat (SETTLE_CYCLES) @(posedge aclk);
    endtask

    // configure, stream whole frames, optionally retune stride and coefficients
    // partway through (block drained first), then drain
    task automatic run_frames(input logic [IMG_DIM_W-1:0] w_reg, h_reg,
                              input logic [KDIM_W-1:0] kr_reg, kc_reg,
                              input logic [STRIDE_W-1:0] st_reg,
                              input logic [CFG_W-1:0] ca, cb,
                              input logic [COEFF_SLOT_W-1:0] cc,
                              input int frames, input int fill, input bit mid_change);
        int unsigned total, split;
        total = window_sum_board::saturate(w_reg, MAX_COLS) *
                window_sum_board::saturate(h_reg, MAX_HEIGHT) * frames;
        split = (mid_change && total > 1) ? $urandom_range(1, total - 1) : total;
        write_reg(CFG_IMAGE_WIDTH,  with_junk(CFG_W'(w_reg), IMG_DIM_W));
        write_reg(CFG_IMAGE_HEIGHT, with_junk(CFG_W'(h_reg), IMG_DIM_W));
        write_reg(CFG_KERNEL_ROWS,  with_junk(CFG_W'(kr_reg), KDIM_W));
        write_reg(CFG_KERNEL_COLS,  with_junk(CFG_W'(kc_reg), KDIM_W));
        write_reg(CFG_STRIDE,       with_junk(CFG_W'(st_reg), STRIDE_W));
        write_reg(CFG_COEFF_A,      ca);
        write_reg(CFG_COEFF_B,      cb);
        write_reg(CFG_COEFF_C,      with_junk(CFG_W'(cc), COEFF_SLOT_W));
        cfg_we <= 1'b0;
        for (int unsigned n = 0; n < total; n++) begin
            if (n == split) begin
                drain_results();
                write_reg(CFG_STRIDE, CFG_W'($urandom_range(0, 7)));
                write_reg(CFG_COEFF_A, {$urandom, $urandom});
                cfg_we <= 1'b0;
            end
            send_pixel((fill < 0) ? random_pixel() : IN_PIXEL_W'(fill));
        end
        drain_results();
    endtask

    initial begin : stimulus
        int                      start_count;
        logic [IMG_DIM_W-1:0]    w, h;
        logic [KDIM_W-1:0]       kr, kc;
        logic [STRIDE_W-1:0]     st;
        board = new();
        repeat (4) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // most negative and most positive window sums: full 3x3 of max pixels
        run_frames(11'd3, 11'd3, 2'd3, 2'd3, 3'd1, {4{16'h8000}}, {4{16'h8000}},
                   16'h8000, 1, 255, 1'b0);
        run_frames(11'd3, 11'd3, 2'd3, 2'd3, 3'd1, {4{16'h7fff}}, {4{16'h7fff}},
                   16'h7fff, 1, 255, 1'b0);
        // image smaller than the kernel: no results, counters still wrap
        run_frames(11'd2, 11'd2, 2'd3, 2'd3, 3'd1, {$urandom, $urandom},
                   {$urandom, $urandom}, 16'($urandom), 1, 0, 1'b0);

        // zero kernel sizes and zero stride act as 1
        run_frames(11'd14, 11'd2, 2'd0, 2'd0, 3'd0, {$urandom, $urandom},
                   {$urandom, $urandom}, 16'($urandom), 1, -1, 1'b0);
        // single column, stride code 7 saturates to 4
        run_frames(11'd1, 11'd12, 2'd3, 2'd1, 3'd7, {$urandom, $urandom},
                   {$urandom, $urandom}, 16'($urandom), 1, -1, 1'b0);

        // sink holds off while the sender streams flat out: result queue fills
        backlog_req <= 1'b1;
        no_gaps <= 1'b1;
        run_frames(11'd10, 11'd8, 2'd3, 2'd3, 3'd1, {$urandom, $urandom},
                   {$urandom, $urandom}, 16'($urandom), 2, -1, 1'b0);
        backlog_req <= 1'b0;
        no_gaps <= 1'b0;

        // random settings on small images, the out-of-range codes included
        start_count = pixels_sent;
        while (pixels_sent < start_count + RANDOM_PIXELS) begin
            w  = ($urandom_range(0, 15) == 0) ? 11'd0 : 11'($urandom_range(1, 14));
            h  = ($urandom_range(0, 15) == 0) ? 11'd0 : 11'($urandom_range(1, 10));
            kr = 2'($urandom_range(0, 3));
            kc = 2'($urandom_range(0, 3));
            st = 3'($urandom_range(0, 7));
            if ($urandom_range(0, 7) == 0) begin
                backlog_req <= 1'b1;
                no_gaps <= 1'b1;
            end
            run_frames(w, h, kr, kc, st, {$urandom, $urandom}, {$urandom, $urandom},
                       16'($urandom), $urandom_range(1, 3), -1,
                       ($urandom_range(0, 3) == 0));
            backlog_req <= 1'b0;
            no_gaps <= 1'b0;
        end

        repeat (SETTLE_CYCLES) @(posedge aclk);
        if (board.errors == 0 && board.expected_sums.size() == 0) begin
            $display("TB_OK");
        end else begin
            $display("TB_ERROR");
        end
        $finish;
    end
endmodule

/* filelist.f */
+incdir+sv
sv/sc2d_pkg.sv
sv/sc2d_cell.sv
sv/sc2d_linebuf.sv
sv/sc2d_ofifo.sv
sv/strided_2d_convolution.sv
tb/tb.sv
